@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL files; only bma_seq.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define BMA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off while reset is low.
`define BMA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/bma_pkg.sv @@
package bma_pkg;

    localparam int MAX_EXP   = 20;
    localparam int MIN_EXP   = 5;
    localparam int HDR_BYTES = 24;

    localparam int ADDR_W  = 48;
    localparam int SIZE_W  = 21;
    localparam int CNT_W   = 16;
    localparam int TYPE_W  = 2;
    localparam int ST_W    = 2;
    localparam int CEXP_W  = 5;
    localparam int CIDX_W  = 1;
    localparam int CDATA_W = 48;

    localparam int SLOT_W = MAX_EXP - MIN_EXP;
    localparam int LVLS   = SLOT_W + 1;
    localparam int LVL_W  = (LVLS > 1) ? $clog2(LVLS) : 1;
    localparam int EXP_W  = $clog2(MAX_EXP + 2);
    localparam int NEED_W = SIZE_W + 1;
    localparam int CMP_W  = (NEED_W > MAX_EXP + 1) ? NEED_W : MAX_EXP + 1;
    localparam int RESET_EXP = (20 > MAX_EXP) ? MAX_EXP : 20;

    localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_INFO  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_BADFREE = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_BASE = 1'd0;
    localparam logic [CIDX_W-1:0] CFG_EXP  = 1'd1;

    typedef struct packed {
        logic             valid;
        logic             used;
        logic [EXP_W-1:0] exp;
    } t_hdr;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] idx;
    } t_link;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [EXP_W-1:0]  exp;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] free_addr;
        logic [SIZE_W-1:0] req_size;
        logic [TYPE_W-1:0] req_type;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0]  block_count;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  used_count;
        logic [SIZE_W-1:0] free_bytes;
        logic [SIZE_W-1:0] used_bytes;
        logic [SIZE_W-1:0] total_bytes;
        logic [ADDR_W-1:0] alloc_addr;
        logic [ST_W-1:0]   status;
    } t_result;

    function automatic logic [LVL_W-1:0] lv_of(input logic [EXP_W-1:0] e);
        lv_of = LVL_W'(e - EXP_W'(MIN_EXP));
    endfunction

endpackage

@@ hw/rtl/bma_ram.sv @@
module bma_ram #(
    parameter int W  = 8,
    parameter int AW = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [2**AW];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bma_seq.sv @@
`include "assert_macros.svh"

module bma_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_init,
    input  bma_pkg::t_cfg    i_cfg,
    input  logic             i_start,
    input  bma_pkg::t_req    i_req,
    input  logic             i_res_ready,
    output logic             o_idle,
    output logic             o_res_valid,
    output bma_pkg::t_result o_res
);

    localparam int SW = bma_pkg::SLOT_W;
    localparam int EW = bma_pkg::EXP_W;
    localparam int AW = bma_pkg::ADDR_W;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_A_RND, S_A_FIND, S_A_S0, S_A_S1, S_A_S2, S_A_S3,
        S_A_TAKE, S_A_MARK, S_A_ADD, S_F_SUB, S_F_CHK, S_F_HDR, S_F_M0,
        S_F_M1, S_F_M2, S_I0, S_I1, S_U0, S_U1, S_P0, S_P1, S_DONE
    } t_state;

    t_state                       r_state;
    t_state                       r_ret;
    logic [SW-1:0]                r_slot;
    logic [EW-1:0]                r_e;
    logic [EW-1:0]                r_top;
    logic [SW-1:0]                r_uslot;
    logic [bma_pkg::LVL_W-1:0]    r_ulv;
    logic [SW-1:0]                r_pslot;
    logic [EW-1:0]                r_pe;
    logic [SW-1:0]                r_lvl_head [bma_pkg::LVLS];
    logic [bma_pkg::LVLS-1:0]     r_lvl_ok;
    logic [bma_pkg::NEED_W-1:0]   r_need;
    logic [AW-1:0]                r_acc;
    logic [SW:0]                  r_cnt;
    logic [bma_pkg::SIZE_W-1:0]   r_used;
    logic [bma_pkg::SIZE_W-1:0]   r_free;
    logic [bma_pkg::CNT_W-1:0]    r_uc;
    logic [bma_pkg::CNT_W-1:0]    r_fc;
    logic [bma_pkg::CNT_W-1:0]    r_bc;
    bma_pkg::t_req                r_req;
    bma_pkg::t_result             r_res;

    logic                  hdr_we, hdr_re, nxt_we, nxt_re, prv_we, prv_re;
    logic [SW-1:0]         hdr_wa, hdr_ra, nxt_wa, prv_wa, lnk_ra;
    bma_pkg::t_hdr         hdr_wd, hdr_rd;
    bma_pkg::t_link        nxt_wd, nxt_rd, prv_wd, prv_rd;

    logic [AW-1:0]         add_a, add_b, add_sum;
    logic                  add_sub;

    logic [SW:0]           lim;
    logic [SW-1:0]         bud, half, left, other;
    logic [bma_pkg::LVL_W-1:0] plv, tlv, elv;
    logic [bma_pkg::CMP_W-1:0] pw;
    logic [EW-1:0]         ee;
    logic                  off_bad;
    logic                  bud_ok;

    assign lim  = (SW+1)'(1) << (i_cfg.exp - EW'(bma_pkg::MIN_EXP));
    assign bud  = r_slot ^ (SW'(1) << (r_e - EW'(bma_pkg::MIN_EXP)));
    assign half = SW'(1) << (r_top - EW'(bma_pkg::MIN_EXP + 1));
    assign left  = (r_slot < r_uslot) ? r_slot : r_uslot;
    assign other = r_slot ^ r_uslot ^ left;
    assign plv  = bma_pkg::lv_of(r_pe);
    assign tlv  = bma_pkg::lv_of(r_top);
    assign elv  = bma_pkg::lv_of(r_e);
    assign pw   = bma_pkg::CMP_W'(1) << r_e;
    assign ee   = (hdr_rd.valid && hdr_rd.exp >= EW'(bma_pkg::MIN_EXP)
                   && hdr_rd.exp <= EW'(bma_pkg::MAX_EXP)) ? hdr_rd.exp
                                                          : EW'(bma_pkg::MIN_EXP);
    assign bud_ok  = hdr_rd.valid && !hdr_rd.used && (hdr_rd.exp == r_e);
    assign off_bad = ((add_sum >> i_cfg.exp) != '0)
                     || (add_sum[bma_pkg::MIN_EXP-1:0] != '0);

    // shared adder
    always_comb begin
        add_a   = r_acc;
        add_b   = AW'(bma_pkg::HDR_BYTES);
        add_sub = 1'b0;
        case (r_state)
            S_F_SUB: begin
                add_a   = r_req.free_addr;
                add_b   = i_cfg.base;
                add_sub = 1'b1;
            end
            S_F_CHK: begin
                add_sub = 1'b1;
            end
            S_A_MARK: begin
                add_a = i_cfg.base;
                add_b = AW'({r_uslot, bma_pkg::MIN_EXP'(0)});
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
        add_sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
    end

    always_comb begin
        hdr_we = 1'b0;
        hdr_wa = r_pslot;
        hdr_wd = '0;
        hdr_re = 1'b0;
        hdr_ra = bud;
        nxt_we = 1'b0;
        nxt_wa = r_pslot;
        nxt_wd = '0;
        nxt_re = 1'b0;
        prv_we = 1'b0;
        prv_wa = r_pslot;
        prv_wd = '0;
        prv_re = 1'b0;
        lnk_ra = r_uslot;
        case (r_state)
            S_CLR: begin
                hdr_we = 1'b1;
                hdr_wa = r_cnt[SW-1:0];
            end
            S_F_CHK: begin
                hdr_re = 1'b1;
                hdr_ra = add_sum[bma_pkg::MIN_EXP +: SW];
            end
            S_F_M0: begin
                hdr_re = (r_e < i_cfg.exp);
                nxt_re = (r_e < i_cfg.exp);
                prv_re = (r_e < i_cfg.exp);
                lnk_ra = bud;
            end
            S_F_M2: begin
                hdr_we = 1'b1;
                hdr_wa = other;
                hdr_wd = '{valid: 1'b0, used: 1'b0, exp: r_e};
            end
            S_I0: begin
                hdr_re = 1'b1;
                hdr_ra = r_cnt[SW-1:0];
            end
            S_A_MARK: begin
                hdr_we = 1'b1;
                hdr_wa = r_uslot;
                hdr_wd = '{valid: 1'b1, used: 1'b1, exp: r_e};
            end
            S_U0: begin
                nxt_re = 1'b1;
                prv_re = 1'b1;
            end
            S_U1: begin
                nxt_we = prv_rd.ok;
                nxt_wa = prv_rd.idx;
                nxt_wd = nxt_rd;
                prv_we = nxt_rd.ok;
                prv_wa = nxt_rd.idx;
                prv_wd = prv_rd;
            end
            S_P0: begin
                hdr_we = 1'b1;
                hdr_wd = '{valid: 1'b1, used: 1'b0, exp: r_pe};
                nxt_we = 1'b1;
                nxt_wd = '{ok: r_lvl_ok[plv], idx: r_lvl_head[plv]};
                prv_we = 1'b1;
            end
            S_P1: begin
                prv_we = r_lvl_ok[plv];
                prv_wa = r_lvl_head[plv];
                prv_wd = '{ok: 1'b1, idx: r_pslot};
            end
            default: begin
                hdr_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_lvl_ok <= '0;
        end else if (i_init) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_lvl_ok <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_lvl_ok <= '0;
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == lim - 1'b1) begin
                        r_pslot <= '0;
                        r_pe    <= i_cfg.exp;
                        r_ret   <= S_IDLE;
                        r_state <= S_P0;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_req  <= i_req;
                        r_res  <= '0;
                        r_need <= bma_pkg::NEED_W'(i_req.req_size)
                                  + bma_pkg::NEED_W'(bma_pkg::HDR_BYTES);
                        r_e    <= EW'(bma_pkg::MIN_EXP);
                        r_cnt  <= '0;
                        r_used <= '0;
                        r_free <= '0;
                        r_uc   <= '0;
                        r_fc   <= '0;
                        r_bc   <= '0;
                        case (i_req.req_type)
                            bma_pkg::REQ_ALLOC: r_state <= S_A_RND;
                            bma_pkg::REQ_FREE:  r_state <= S_F_SUB;
                            bma_pkg::REQ_INFO:  r_state <= S_I0;
                            default:            r_state <= S_DONE;
                        endcase
                    end
                end
                S_A_RND: begin
                    if (pw < bma_pkg::CMP_W'(r_need)) begin
                        if (r_e < i_cfg.exp) begin
                            r_e <= r_e + 1'b1;
                        end else begin
                            r_res.status <= bma_pkg::ST_NOSPACE;
                            r_state      <= S_DONE;
                        end
                    end else begin
                        r_top   <= r_e;
                        r_state <= S_A_FIND;
                    end
                end
                S_A_FIND: begin
                    if (r_top > i_cfg.exp) begin
                        r_res.status <= bma_pkg::ST_NOSPACE;
                        r_state      <= S_DONE;
                    end else if (r_lvl_ok[tlv]) begin
                        r_state <= (r_top == r_e) ? S_A_TAKE : S_A_S0;
                    end else begin
                        r_top <= r_top + 1'b1;
                    end
                end
                S_A_S0: begin
                    r_uslot <= r_lvl_head[tlv];
                    r_ulv   <= tlv;
                    r_ret   <= S_A_S1;
                    r_state <= S_U0;
                end
                S_A_S1: begin
                    r_pslot <= r_uslot + half;
                    r_pe    <= r_top - 1'b1;
                    r_ret   <= S_A_S2;
                    r_state <= S_P0;
                end
                S_A_S2: begin
                    r_pslot <= r_uslot;
                    r_ret   <= S_A_S3;
                    r_state <= S_P0;
                end
                S_A_S3: begin
                    r_top   <= r_top - 1'b1;
                    r_state <= (r_top - 1'b1 > r_e) ? S_A_S0 : S_A_TAKE;
                end
                S_A_TAKE: begin
                    r_uslot <= r_lvl_head[elv];
                    r_ulv   <= elv;
                    r_ret   <= S_A_MARK;
                    r_state <= S_U0;
                end
                S_A_MARK: begin
                    r_acc   <= add_sum;
                    r_state <= S_A_ADD;
                end
                S_A_ADD: begin
                    r_res.status     <= bma_pkg::ST_OK;
                    r_res.alloc_addr <= add_sum;
                    r_state          <= S_DONE;
                end
                S_F_SUB: begin
                    r_acc   <= add_sum;
                    r_state <= S_F_CHK;
                end
                S_F_CHK: begin
                    r_slot <= add_sum[bma_pkg::MIN_EXP +: SW];
                    if (off_bad) begin
                        r_res.status <= bma_pkg::ST_BADFREE;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_F_HDR;
                    end
                end
                S_F_HDR: begin
                    if (!hdr_rd.valid || !hdr_rd.used) begin
                        r_res.status <= bma_pkg::ST_BADFREE;
                        r_state      <= S_DONE;
                    end else begin
                        r_e     <= hdr_rd.exp;
                        r_state <= S_F_M0;
                    end
                end
                S_F_M0: begin
                    if (r_e < i_cfg.exp) begin
                        r_uslot <= bud;
                        r_state <= S_F_M1;
                    end else begin
                        r_pslot <= r_slot;
                        r_pe    <= r_e;
                        r_ret   <= S_DONE;
                        r_state <= S_P0;
                    end
                end
                S_F_M1: begin
                    if (bud_ok) begin
                        r_ulv   <= elv;
                        r_ret   <= S_F_M2;
                        r_state <= S_U1;
                    end else begin
                        r_pslot <= r_slot;
                        r_pe    <= r_e;
                        r_ret   <= S_DONE;
                        r_state <= S_P0;
                    end
                end
                S_F_M2: begin
                    r_slot  <= left;
                    r_e     <= r_e + 1'b1;
                    r_state <= S_F_M0;
                end
                S_I0: begin
                    if (r_cnt >= lim) begin
                        r_res.total_bytes <= bma_pkg::SIZE_W'(1) << i_cfg.exp;
                        r_res.used_bytes  <= r_used;
                        r_res.free_bytes  <= r_free;
                        r_res.used_count  <= r_uc;
                        r_res.free_count  <= r_fc;
                        r_res.block_count <= r_bc;
                        r_state           <= S_DONE;
                    end else begin
                        r_state <= S_I1;
                    end
                end
                S_I1: begin
                    r_bc <= r_bc + 1'b1;
                    if (hdr_rd.used) begin
                        r_uc   <= r_uc + 1'b1;
                        r_used <= r_used + (bma_pkg::SIZE_W'(1) << ee);
                    end else begin
                        r_fc   <= r_fc + 1'b1;
                        r_free <= r_free + (bma_pkg::SIZE_W'(1) << ee);
                    end
                    r_cnt   <= r_cnt + ((SW+1)'(1) << (ee - EW'(bma_pkg::MIN_EXP)));
                    r_state <= S_I0;
                end
                S_U0: begin
                    r_state <= S_U1;
                end
                S_U1: begin
                    if (!prv_rd.ok) begin
                        r_lvl_head[r_ulv] <= nxt_rd.idx;
                        r_lvl_ok[r_ulv]   <= nxt_rd.ok;
                    end
                    r_state <= r_ret;
                end
                S_P0: begin
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_lvl_head[plv] <= r_pslot;
                    r_lvl_ok[plv]   <= 1'b1;
                    r_state         <= r_ret;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    bma_ram #(.W($bits(bma_pkg::t_hdr)), .AW(SW)) u_hdr (
        .i_clk   (i_clk),
        .i_we    (hdr_we),
        .i_waddr (hdr_wa),
        .i_wdata (hdr_wd),
        .i_re    (hdr_re),
        .i_raddr (hdr_ra),
        .o_rdata (hdr_rd)
    );

    bma_ram #(.W($bits(bma_pkg::t_link)), .AW(SW)) u_nxt (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_wa),
        .i_wdata (nxt_wd),
        .i_re    (nxt_re),
        .i_raddr (lnk_ra),
        .o_rdata (nxt_rd)
    );

    bma_ram #(.W($bits(bma_pkg::t_link)), .AW(SW)) u_prv (
        .i_clk   (i_clk),
        .i_we    (prv_we),
        .i_waddr (prv_wa),
        .i_wdata (prv_wd),
        .i_re    (prv_re),
        .i_raddr (lnk_ra),
        .o_rdata (prv_rd)
    );

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    `BMA_ASSERT_NXT(a_start_leaves_idle, i_clk, i_rst_n, i_start && !i_init,
                    r_state != S_IDLE)
    `BMA_ASSERT_IMP(a_split_src_nonempty, i_clk, i_rst_n, r_state == S_A_S0,
                    r_lvl_ok[tlv])
    `BMA_ASSERT_IMP(a_merge_within_arena, i_clk, i_rst_n, r_state == S_F_M0,
                    r_e <= i_cfg.exp)

endmodule

@@ hw/rtl/buddy_memory_allocator.sv @@
// Binary buddy allocator over a 2^arena_exp byte arena of 32-byte slots.
// Requests arrive on the s_axis channel, one transaction per request
// (allocate, free or usage query); each gives exactly one result transaction
// on the m_axis channel. s_axis_tready is high only while the sequencer is
// idle, so one request is worked at a time.
// The sequencer walks the slot header and link memories (one read port and
// one write port each) step by step for each request:
//   allocate: rounds the size up to a block, searches the levels, then
//             splits larger blocks down and takes the block off its list.
//   free:     checks the address, merges with each free buddy, then inserts
//             the final block into its free list. query: walks every block.
// A finished result sits in an output register; the next request is taken
// while it waits. If the receiver stalls, the sequencer holds in its done
// state until the register frees. Reset, and any write of arena_exp, start
// a clearing pass over all 2^(arena_exp-5) slots that leaves one free block;
// no request is taken during it. Configuration writes are taken at any time
// but must only be issued while the block is idle.
module buddy_memory_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // req_type[1:0], req_size[22:2], free_addr[70:23]
    input  logic [71:0]                  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // status[1:0], alloc_addr[49:2], total_bytes[70:50], used_bytes[91:71],
    // free_bytes[112:92], used_count[128:113], free_count[144:129],
    // block_count[160:145]
    output logic [167:0]                 m_axis_tdata,
    input  logic                         i_cfg_we,
    input  logic [bma_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [bma_pkg::CDATA_W-1:0]  i_cfg_wdata
);

    bma_pkg::t_cfg    r_cfg;
    logic             r_ovalid;
    bma_pkg::t_result r_odata;

    bma_pkg::t_req    req;
    bma_pkg::t_result res;
    logic             seq_idle, res_valid, out_free, init;
    logic [bma_pkg::CEXP_W-1:0] wexp;
    logic [bma_pkg::EXP_W-1:0]  cexp;

    assign req      = bma_pkg::t_req'(s_axis_tdata[$bits(bma_pkg::t_req)-1:0]);
    assign out_free = !r_ovalid || m_axis_tready;
    assign init     = i_cfg_we && (i_cfg_idx == bma_pkg::CFG_EXP);
    assign wexp     = i_cfg_wdata[bma_pkg::CEXP_W-1:0];

    always_comb begin
        cexp = bma_pkg::EXP_W'(wexp);
        if (wexp < bma_pkg::CEXP_W'(bma_pkg::MIN_EXP)) begin
            cexp = bma_pkg::EXP_W'(bma_pkg::MIN_EXP);
        end else if (wexp > bma_pkg::CEXP_W'(bma_pkg::MAX_EXP)) begin
            cexp = bma_pkg::EXP_W'(bma_pkg::MAX_EXP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base <= '0;
            r_cfg.exp  <= bma_pkg::EXP_W'(bma_pkg::RESET_EXP);
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bma_pkg::CFG_BASE: r_cfg.base <= i_cfg_wdata[bma_pkg::ADDR_W-1:0];
                    bma_pkg::CFG_EXP:  r_cfg.exp  <= cexp;
                    default:           r_cfg      <= r_cfg;
                endcase
            end
            if (res_valid && out_free) begin
                r_ovalid <= 1'b1;
                r_odata  <= res;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    bma_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init      (init),
        .i_cfg       (r_cfg),
        .i_start     (s_axis_tvalid && s_axis_tready),
        .i_req       (req),
        .i_res_ready (out_free),
        .o_idle      (seq_idle),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign s_axis_tready = seq_idle;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {(168 - $bits(bma_pkg::t_result))'(0), r_odata};

endmodule

@@ bench/buddy_memory_allocator_chk.sv @@
`timescale 1ns / 1ps

module buddy_memory_allocator_chk
    import bma_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [71:0]         i_s_tdata,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [167:0]        i_m_tdata,
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_idx,
    input  logic [CDATA_W-1:0]  i_cfg_wdata,
    output int                  o_errors,
    output int                  o_pending
);

    localparam int SLOTS = 1 << SLOT_W;

    logic [4:0]        blk_exp   [SLOTS];
    bit                blk_used  [SLOTS];
    bit                blk_start [SLOTS];
    logic [SLOT_W-1:0] nxt       [SLOTS];
    logic [SLOT_W-1:0] prv       [SLOTS];
    bit                nxt_ok    [SLOTS];
    bit                prv_ok    [SLOTS];
    logic [SLOT_W-1:0] lvl_head  [LVLS];
    bit                lvl_ok    [LVLS];
    logic [ADDR_W-1:0] arena_base;
    int unsigned       arena_exp;

    t_result due_results[$];
    int      errors;

    assign o_errors  = errors;
    assign o_pending = due_results.size();

    function automatic void push_free(int unsigned s, int unsigned e);
        int unsigned lv;
        lv = e - MIN_EXP;
        blk_exp[s]   = 5'(e);
        blk_used[s]  = 1'b0;
        blk_start[s] = 1'b1;
        prv_ok[s]    = 1'b0;
        prv[s]       = '0;
        nxt_ok[s]    = lvl_ok[lv];
        nxt[s]       = lvl_head[lv];
        if (lvl_ok[lv]) begin
            prv[lvl_head[lv]]    = SLOT_W'(s);
            prv_ok[lvl_head[lv]] = 1'b1;
        end
        lvl_head[lv] = SLOT_W'(s);
        lvl_ok[lv]   = 1'b1;
    endfunction

    function automatic void unlink(int unsigned s);
        int unsigned lv;
        lv = blk_exp[s] - MIN_EXP;
        if (prv_ok[s]) begin
            nxt[prv[s]]    = nxt[s];
            nxt_ok[prv[s]] = nxt_ok[s];
        end else begin
            lvl_head[lv] = nxt[s];
            lvl_ok[lv]   = nxt_ok[s];
        end
        if (nxt_ok[s]) begin
            prv[nxt[s]]    = prv[s];
            prv_ok[nxt[s]] = prv_ok[s];
        end
        nxt_ok[s] = 1'b0;
        prv_ok[s] = 1'b0;
    endfunction

    function automatic void clear_arena();
        for (int i = 0; i < SLOTS; i++) begin
            blk_exp[i]   = '0;
            blk_used[i]  = 1'b0;
            blk_start[i] = 1'b0;
            nxt[i]       = '0;
            prv[i]       = '0;
            nxt_ok[i]    = 1'b0;
            prv_ok[i]    = 1'b0;
        end
        for (int i = 0; i < LVLS; i++) begin
            lvl_head[i] = '0;
            lvl_ok[i]   = 1'b0;
        end
        push_free(0, arena_exp);
    endfunction

    function automatic t_result carve_block(logic [SIZE_W-1:0] size);
        t_result     r;
        longint      need;
        int unsigned e, top, blk, half, s;
        r    = '0;
        need = longint'(size) + HDR_BYTES;
        e    = MIN_EXP;
        while ((64'd1 << e) < need && e < arena_exp) e++;
        if ((64'd1 << e) < need) begin
            r.status = ST_NOSPACE;
            return r;
        end
        top = e;
        while (top <= arena_exp && !lvl_ok[top - MIN_EXP]) top++;
        if (top > arena_exp) begin
            r.status = ST_NOSPACE;
            return r;
        end
        while (top > e) begin
            blk  = lvl_head[top - MIN_EXP];
            half = 1 << (top - 1 - MIN_EXP);
            unlink(blk);
            push_free(blk + half, top - 1);
            push_free(blk, top - 1);
            top--;
        end
        s = lvl_head[e - MIN_EXP];
        unlink(s);
        blk_used[s]  = 1'b1;
        r.status     = ST_OK;
        r.alloc_addr = arena_base + ADDR_W'(s << MIN_EXP) + ADDR_W'(HDR_BYTES);
        return r;
    endfunction

    function automatic t_result release_block(logic [ADDR_W-1:0] addr);
        t_result           r;
        logic [ADDR_W-1:0] off;
        int unsigned       s, e, bud, left;
        r   = '0;
        off = addr - arena_base - ADDR_W'(HDR_BYTES);
        if (off >= (48'd1 << arena_exp) || off[MIN_EXP-1:0] != '0) begin
            r.status = ST_BADFREE;
            return r;
        end
        s = off >> MIN_EXP;
        if (!blk_start[s] || !blk_used[s]) begin
            r.status = ST_BADFREE;
            return r;
        end
        blk_used[s] = 1'b0;
        e = blk_exp[s];
        while (e < arena_exp) begin
            bud = s ^ (1 << (e - MIN_EXP));
            if (bud >= SLOTS || !blk_start[bud] || blk_used[bud] || blk_exp[bud] != e)
                break;
            unlink(bud);
            left = (s < bud) ? s : bud;
            blk_start[s ^ bud ^ left] = 1'b0;
            s = left;
            e++;
            blk_exp[s] = 5'(e);
        end
        push_free(s, e);
        r.status = ST_OK;
        return r;
    endfunction

    function automatic t_result tally_arena();
        t_result     r;
        int unsigned lim, s, e;
        longint      used, fre, uc, fc, bc;
        r    = '0;
        lim  = 1 << (arena_exp - MIN_EXP);
        s    = 0;
        used = 0; fre = 0; uc = 0; fc = 0; bc = 0;
        while (s < lim) begin
            e = blk_exp[s];
            if (!blk_start[s] || e < MIN_EXP || e > MAX_EXP) e = MIN_EXP;
            bc++;
            if (blk_used[s]) begin
                uc++;
                used += longint'(1) << e;
            end else begin
                fc++;
                fre += longint'(1) << e;
            end
            s += 1 << (e - MIN_EXP);
        end
        r.status      = ST_OK;
        r.total_bytes = SIZE_W'(longint'(1) << arena_exp);
        r.used_bytes  = SIZE_W'(used);
        r.free_bytes  = SIZE_W'(fre);
        r.used_count  = CNT_W'(uc);
        r.free_count  = CNT_W'(fc);
        r.block_count = CNT_W'(bc);
        return r;
    endfunction

    function automatic t_result serve_request(t_req q);
        t_result r;
        r = '0;
        case (q.req_type)
            REQ_ALLOC: r = carve_block(q.req_size);
            REQ_FREE:  r = release_block(q.free_addr);
            REQ_INFO:  r = tally_arena();
            default:   r = '0;
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    bit      reset_seen;
    t_result want, got;
    logic [4:0] new_exp;

    initial begin
        errors     = 0;
        reset_seen = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            if (!reset_seen) begin
                arena_base = '0;
                arena_exp  = RESET_EXP;
                clear_arena();
                reset_seen = 1'b1;
            end
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BASE) begin
                    arena_base = i_cfg_wdata[ADDR_W-1:0];
                end else if (i_cfg_idx == CFG_EXP) begin
                    new_exp = i_cfg_wdata[4:0];
                    if (new_exp < MIN_EXP) new_exp = MIN_EXP;
                    if (new_exp > MAX_EXP) new_exp = MAX_EXP;
                    arena_exp = new_exp;
                    clear_arena();
                end
            end
            if (i_s_tvalid && i_s_tready)
                due_results.push_back(serve_request(t_req'(i_s_tdata[70:0])));
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[160:0]);
                if (due_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                end else begin
                    want = due_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("alloc_addr", want.alloc_addr, got.alloc_addr);
                    check_field("total_bytes", want.total_bytes, got.total_bytes);
                    check_field("used_bytes", want.used_bytes, got.used_bytes);
                    check_field("free_bytes", want.free_bytes, got.free_bytes);
                    check_field("used_count", want.used_count, got.used_count);
                    check_field("free_count", want.free_count, got.free_count);
                    check_field("block_count", want.block_count, got.block_count);
                end
            end
        end
    end

endmodule

@@ bench/buddy_memory_allocator_tb.sv @@
`timescale 1ns / 1ps

module buddy_memory_allocator_tb;
    import bma_pkg::*;

    localparam logic [TYPE_W-1:0] REQ_NONE = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [71:0]         s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [167:0]        m_axis_tdata;
    logic                i_cfg_we;
    logic [CIDX_W-1:0]   i_cfg_idx;
    logic [CDATA_W-1:0]  i_cfg_wdata;
    int                  errors;
    int                  pending;

    int unsigned         cur_exp;
    int                  sent;
    int                  results;
    logic [ADDR_W-1:0]   live[$];
    logic [ADDR_W-1:0]   freed[$];
    logic [TYPE_W-1:0]   sent_types[$];

    buddy_memory_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    buddy_memory_allocator_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("buddy_memory_allocator verification failed");
        $finish;
    end

    // track handed-out addresses to seed frees
    t_result seen;
    t_req    seen_req;
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            seen_req = t_req'(s_axis_tdata[70:0]);
            sent_types.push_back(seen_req.req_type);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = t_result'(m_axis_tdata[160:0]);
            if (sent_types.size() > 0 && sent_types.pop_front() == REQ_ALLOC
                    && seen.status == ST_OK)
                live.push_back(seen.alloc_addr);
        end
    end

    initial begin
        int gap;
        m_axis_tready = 1'b0;
        results = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ((results / 40) % 3 == 0) ? 0 : $urandom_range(0, 9);
            if (results == 100) gap = 400;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            results++;
        end
    end

    task automatic send_req(logic [TYPE_W-1:0] kind, logic [SIZE_W-1:0] size,
                            logic [ADDR_W-1:0] addr);
        t_req q;
        int   gap;
        q.req_type  = kind;
        q.req_size  = size;
        q.free_addr = addr;
        gap = ((sent / 50) % 3 == 1) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, q};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_item();
        int unsigned       pick, idx;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 48 || (pick < 88 && live.size() == 0)) begin
            idx = $urandom_range(0, 99);
            if (idx < 60)      size = $urandom_range(0, 100);
            else if (idx < 85) size = $urandom_range(0, (1 << cur_exp) / 8);
            else if (idx < 95) size = $urandom_range(0, 1 << cur_exp);
            else               size = SIZE_W'($urandom);
            send_req(REQ_ALLOC, size, '0);
        end else if (pick < 88) begin
            idx = $urandom_range(0, 99);
            if (idx < 75 && live.size() > 0) begin
                pick = $urandom_range(0, live.size() - 1);
                addr = live[pick];
                live.delete(pick);
                freed.push_back(addr);
            end else if (idx < 85 && freed.size() > 0) begin
                addr = freed[$urandom_range(0, freed.size() - 1)];
            end else if (idx < 92 && live.size() > 0) begin
                addr = live[$urandom_range(0, live.size() - 1)]
                       + ADDR_W'($urandom_range(1, 40));
            end else begin
                addr = {16'($urandom), 32'($urandom)};
            end
            send_req(REQ_FREE, SIZE_W'($urandom), addr);
        end else if (pick < 96) begin
            send_req(REQ_INFO, SIZE_W'($urandom), {16'($urandom), 32'($urandom)});
        end else begin
            send_req(REQ_NONE, SIZE_W'($urandom), {16'($urandom), 32'($urandom)});
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] bases [5];
        logic [4:0]        exps  [5];
        int unsigned       eff   [5];
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        sent          = 0;
        cur_exp       = RESET_EXP;
        bases = '{48'h0000_1234_5000, 48'hFFFF_FFFF_FFF0,
                  {16'($urandom), 32'($urandom)}, 48'h0, {16'($urandom), 32'($urandom)}};
        exps  = '{5'd0, 5'd31, 5'd8, 5'd12, 5'd20};
        eff   = '{5, 20, 8, 12, 20};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(REQ_INFO, '0, '0);
        send_req(REQ_ALLOC, 21'd0, '0);
        send_req(REQ_ALLOC, 21'd8, '0);
        send_req(REQ_ALLOC, 21'd9, '0);
        send_req(REQ_ALLOC, 21'd1048576, '0);
        send_req(REQ_ALLOC, 21'h1FFFFF, '0);
        send_req(REQ_ALLOC, 21'd1048552, '0);
        send_req(REQ_INFO, '0, '0);
        send_req(REQ_FREE, '0, 48'd24);
        send_req(REQ_FREE, '0, 48'd24);
        send_req(REQ_FREE, '0, 48'd25);
        send_req(REQ_FREE, '0, 48'd0);
        send_req(REQ_FREE, '0, 48'hFFFF_FFFF_FFFF);
        send_req(REQ_FREE, '0, 48'd88);
        send_req(REQ_FREE, '0, 48'd56);
        send_req(REQ_NONE, 21'h1FFFFF, 48'hFFFF_FFFF_FFFF);
        send_req(REQ_INFO, '0, '0);
        send_req(REQ_ALLOC, 21'd1048552, '0);
        send_req(REQ_FREE, '0, 48'd24 + 48'd1048576);
        send_req(REQ_INFO, '0, '0);
        send_req(REQ_FREE, '0, 48'd24);
        send_req(REQ_INFO, '0, '0);
        drain();
        live.delete();
        freed.delete();

        repeat (110) random_item();
        for (int p = 0; p < 5; p++) begin
            drain();
            live.delete();
            freed.delete();
            write_reg(CFG_BASE, bases[p]);
            write_reg(CFG_EXP, CDATA_W'(exps[p]));
            cur_exp = eff[p];
            repeat (105) random_item();
        end

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("buddy_memory_allocator verification clean");
        end else begin
            $display("buddy_memory_allocator verification failed");
        end
        $finish;
    end

endmodule
